/* hdl/binary_to_decimal_ascii_macros.svh */
// Assertion macros used by the checker file.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/b2da_pkg.sv */
package b2da_pkg;

  localparam int ValueW    = 32;
  localparam int MaxDigits = 10;
  localparam int CapW      = 4;
  localparam int PosW      = 4;
  localparam int CodeW     = 6;
  localparam int StepW     = $clog2(ValueW);

  localparam logic [CapW-1:0]  CapReset = CapW'(MaxDigits + 1);
  localparam logic [CodeW-1:0] CharZero = CodeW'(48);
  localparam logic [CodeW-1:0] CharNul  = CodeW'(0);

  typedef logic [3:0] digit_t;
  typedef digit_t [MaxDigits-1:0] bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the shift-and-correct unit
  typedef struct packed {
    logic load;
  } dab_ctrl_t;

  // Status from the shift-and-correct unit
  typedef struct packed {
    logic last_step;
  } dab_stat_t;

  // Add three to a BCD digit of five or more before the next shift
  function automatic digit_t dab_correct(input digit_t d);
    dab_correct = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

/* hdl/b2da_dabble.sv */
module b2da_dabble (
  input  logic                            clk,
  input  logic                            rst,
  input  b2da_pkg::dab_ctrl_t             ctrl,
  input  logic [b2da_pkg::ValueW-1:0]     value,
  output b2da_pkg::dab_stat_t             stat,
  output b2da_pkg::bcd_t                  bcd
);

  logic [b2da_pkg::ValueW-1:0]         bin;
  logic [b2da_pkg::StepW-1:0]          step;
  logic                                busy;
  b2da_pkg::bcd_t                      bcd_fix;
  logic [$bits(b2da_pkg::bcd_t)-1:0]   fix_bits;

  // Correct every digit, independent of each other
  always_comb begin
    for (int i = 0; i < b2da_pkg::MaxDigits; i++) begin
      bcd_fix[i] = b2da_pkg::dab_correct(bcd[i]);
    end
  end

  assign fix_bits = bcd_fix;

  // Step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (ctrl.load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == b2da_pkg::StepW'(b2da_pkg::ValueW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift one binary bit into the corrected BCD word per cycle while busy; the top bit
  // drops out and is always zero for a 32-bit value
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[b2da_pkg::ValueW-2:0], 1'b0};
      bcd <= {fix_bits[$bits(b2da_pkg::bcd_t)-2:0], bin[b2da_pkg::ValueW-1]};
    end
  end

  assign stat.last_step = busy && (step == b2da_pkg::StepW'(b2da_pkg::ValueW - 1));

endmodule

/* hdl/binary_to_decimal_ascii.sv */
// An accepted item passes through 32 shift steps of the BCD shift-and-correct unit,
// a sizing state and one output register before its first character, then one
// character per cycle while the output is not stalled: digits plus the terminator.
// No new item is taken until the terminator is loaded; with buffer_capacity zero
// an item is accepted and dropped, and ready stays high. Reset: rst is synchronous,
// active high; clears the sequencer and the output valid, and sets capacity 11.
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,      // buffer_capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,        // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,        // [5:0] char_code, [9:6] char_position, zero pad
  output logic        m_tlast         // is_last
);

  b2da_pkg::state_t             state, state_next;
  logic [b2da_pkg::CapW-1:0]    cap;
  logic [b2da_pkg::PosW-1:0]    digit_total, digit_total_next;
  logic [b2da_pkg::PosW-1:0]    emit_index, emit_index_next;
  logic [b2da_pkg::PosW-1:0]    ndig;
  logic [b2da_pkg::PosW-1:0]    slot;
  b2da_pkg::dab_ctrl_t          dctrl;
  b2da_pkg::dab_stat_t          dstat;
  b2da_pkg::bcd_t               bcd;
  logic                         accept;
  logic                         out_free;
  logic                         out_load;
  logic [b2da_pkg::CodeW-1:0]   out_code_next;
  logic                         out_last_next;
  logic [b2da_pkg::CodeW-1:0]   out_code;
  logic [b2da_pkg::PosW-1:0]    out_pos;
  logic                         out_last;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= b2da_pkg::CapReset;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  assign s_tready   = (state == b2da_pkg::ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign dctrl.load = accept && (cap != '0);

  b2da_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (dctrl),
    .value (s_tdata),
    .stat  (dstat),
    .bcd   (bcd)
  );

  // Count significant digits; zero still has one
  always_comb begin
    ndig = b2da_pkg::PosW'(1);
    for (int i = 0; i < b2da_pkg::MaxDigits; i++) begin
      if (bcd[i] != 4'd0) begin
        ndig = b2da_pkg::PosW'(i + 1);
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign slot     = digit_total - emit_index - 1'b1;

  // Sequencer: next state and character selection
  always_comb begin
    state_next       = state;
    digit_total_next = digit_total;
    emit_index_next  = emit_index;
    out_load         = 1'b0;
    out_code_next    = b2da_pkg::CharNul;
    out_last_next    = 1'b0;
    case (state)
      b2da_pkg::ST_IDLE: begin
        if (dctrl.load) begin
          state_next = b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        if (dstat.last_step) begin
          state_next = b2da_pkg::ST_SIZE;
        end
      end
      b2da_pkg::ST_SIZE: begin
        // Keep only the lowest-order digits that fit beside the terminator
        if (ndig >= cap) begin
          digit_total_next = cap - 1'b1;
        end else begin
          digit_total_next = ndig;
        end
        emit_index_next = '0;
        state_next      = b2da_pkg::ST_EMIT;
      end
      b2da_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_index == digit_total) begin
            out_code_next = b2da_pkg::CharNul;
            out_last_next = 1'b1;
            state_next    = b2da_pkg::ST_IDLE;
          end else begin
            out_code_next   = b2da_pkg::CharZero + b2da_pkg::CodeW'(bcd[slot]);
            emit_index_next = emit_index + 1'b1;
          end
        end
      end
      default: begin
        state_next = b2da_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= b2da_pkg::ST_IDLE;
      digit_total <= '0;
      emit_index  <= '0;
    end else begin
      state       <= state_next;
      digit_total <= digit_total_next;
      emit_index  <= emit_index_next;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code <= out_code_next;
      out_pos  <= emit_index;
      out_last <= out_last_next;
    end
  end

  assign m_tdata = {6'd0, out_pos, out_code};
  assign m_tlast = out_last;

endmodule

/* hdl/b2da_checker.sv */
`include "binary_to_decimal_ascii_macros.svh"

module b2da_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [3:0]  cfg_wdata,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  logic [3:0] cap;

  // Track the capacity as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= 4'd11;
    end else if (cfg_we) begin
      cap <= cfg_wdata;
    end
  end

  // Hold a stalled item
  `B2DA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

  // Digits carry an ASCII digit code
  `B2DA_ASSERT_NOW(a_digit, m_tvalid && !m_tlast, m_tdata[5:0] >= 6'd48 && m_tdata[5:0] <= 6'd57, "digit item with a non-digit code")

  // The terminator carries NUL
  `B2DA_ASSERT_NOW(a_nul, m_tvalid && m_tlast, m_tdata[5:0] == 6'd0 && m_tdata[15:10] == 6'd0, "terminator item not NUL")

  // A converting item blocks the input
  `B2DA_ASSERT_NEXT(a_busy, s_tvalid && s_tready && cap != 4'd0, !s_tready, "input ready right after a conversion started")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);
